@@ rtl/tlfq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and interface structs of the feedback queue scheduler.
package tlfq_pkg;

  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 16;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_RAN      = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;

  localparam logic [1:0] CFG_TOP_Q = 2'd0;
  localparam logic [1:0] CFG_MID_Q = 2'd1;
  localparam logic [1:0] CFG_AGING = 2'd2;

  localparam logic [1:0] LVL_TOP = 2'd0;
  localparam logic [1:0] LVL_MID = 2'd1;
  localparam logic [1:0] LVL_BOT = 2'd2;

  localparam logic [5:0] TOP_Q_RST = 6'd8;
  localparam logic [5:0] MID_Q_RST = 6'd16;
  localparam logic [7:0] AGING_RST = 8'd15;
  localparam logic [7:0] CNT8_MAX  = 8'hFF;

  typedef logic [3:0] act_t;
  localparam act_t ACT_NONE     = 4'd0;
  localparam act_t ACT_LATCH    = 4'd1;
  localparam act_t ACT_REJECT   = 4'd2;
  localparam act_t ACT_IDLETICK = 4'd3;
  localparam act_t ACT_HEAD     = 4'd4;
  localparam act_t ACT_SCAN     = 4'd5;
  localparam act_t ACT_ALLOC    = 4'd6;
  localparam act_t ACT_SLOT     = 4'd7;
  localparam act_t ACT_DECIDE   = 4'd8;
  localparam act_t ACT_WRD      = 4'd9;
  localparam act_t ACT_WSLOT    = 4'd10;
  localparam act_t ACT_WUPD     = 4'd11;

  typedef struct packed {
    act_t act;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic burst_zero;
    logic full;
    logic slot_free;
    logic lvl_none;
    logic walk_needed;
    logic walk_last;
  } dp_stat_t;

endpackage

@@ rtl/tlfq_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the scheduler: steps the datapath through arrival, tick and aging walk.
module tlfq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tlfq_pkg::dp_stat_t stat,
  output tlfq_pkg::dp_cmd_t  cmd
);
  import tlfq_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_ALLOC  = 4'd3;
  localparam logic [3:0] S_SLOT   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_WRD    = 4'd6;
  localparam logic [3:0] S_WSLOT  = 4'd7;
  localparam logic [3:0] S_WUPD   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.act   = ACT_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.act   = ACT_LATCH;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.op == OP_ARRIVAL) begin
          if (stat.burst_zero || stat.full) begin
            cmd.act   = ACT_REJECT;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (stat.lvl_none) begin
          cmd.act   = ACT_IDLETICK;
          state_nxt = S_IDLE;
        end else begin
          cmd.act   = ACT_HEAD;
          state_nxt = S_SLOT;
        end
      end
      S_SCAN: begin
        cmd.act = ACT_SCAN;
        if (stat.slot_free) state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.act   = ACT_ALLOC;
        state_nxt = S_IDLE;
      end
      S_SLOT: begin
        cmd.act   = ACT_SLOT;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.act   = ACT_DECIDE;
        state_nxt = stat.walk_needed ? S_WRD : S_IDLE;
      end
      S_WRD: begin
        cmd.act   = ACT_WRD;
        state_nxt = S_WSLOT;
      end
      S_WSLOT: begin
        cmd.act   = ACT_WSLOT;
        state_nxt = S_WUPD;
      end
      S_WUPD: begin
        cmd.act   = ACT_WUPD;
        state_nxt = stat.walk_last ? S_IDLE : S_WRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/tlfq_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the scheduler: job store, level queues, config and result registers.
module tlfq_dp #(
  parameter int MAX_JOBS  = tlfq_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = tlfq_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tlfq_pkg::dp_cmd_t  cmd,
  output tlfq_pkg::dp_stat_t stat,
  input  logic               in_op,
  input  logic [7:0]         in_job_id,
  input  logic [15:0]        in_burst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [7:0]         out_served_id,
  output logic [1:0]         out_served_level,
  output logic [15:0]        out_arrival_stamp,
  output logic [15:0]        out_start_stamp,
  output logic [15:0]        out_finish_stamp
);
  import tlfq_pkg::*;

  localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int FILL_W = $clog2(MAX_JOBS + 1);
  localparam int EXT_W  = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int ST_W   = 2 * TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [FILL_W-1:0]    FILL_MAX = FILL_W'(MAX_JOBS);

  // per-slot store: {id, burst}, {executed, quantum, idle}, {arrival, start, started}
  logic [23:0]       ib_mem [MAX_JOBS];
  logic [31:0]       pr_mem [MAX_JOBS];
  logic [ST_W-1:0]   st_mem [MAX_JOBS];
  logic [SLOT_W-1:0] ord0_mem [MAX_JOBS];
  logic [SLOT_W-1:0] ord1_mem [MAX_JOBS];
  logic [SLOT_W-1:0] ord2_mem [MAX_JOBS];

  logic [23:0]       ib_q;
  logic [31:0]       pr_q;
  logic [ST_W-1:0]   st_q;
  logic [SLOT_W-1:0] ord0_q, ord1_q, ord2_q;

  logic [5:0]           top_q_r, mid_q_r;
  logic [7:0]           aging_r;
  logic                 op_r;
  logic [7:0]           id_r;
  logic [15:0]          burst_r;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [MAX_JOBS-1:0]  in_use_r;
  logic [FILL_W-1:0]    cnt_r;
  logic [FILL_W-1:0]    fill0_r, fill1_r, fill2_r;
  logic [1:0]           lvl_r;
  logic [SLOT_W-1:0]    slot_r, scan_r;
  logic [FILL_W-1:0]    i_r, n_r, n_nxt;
  logic                 removed_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [7:0]           out_id_r;
  logic [1:0]           out_lvl_r;
  logic [15:0]          out_arr_r, out_start_r, out_fin_r;

  logic [SLOT_W-1:0]    ord_raddr, ord_sel;
  logic [FILL_W-1:0]    fill_cur, fill_up, fill_dn;
  logic [FILL_W-1:0]    fill_nxt [3];
  logic                 ord_we [3];
  logic [SLOT_W-1:0]    ord_wa [3];

  logic [15:0]          f_exec, f_burst;
  logic [7:0]           f_quant, f_idle, f_id, quant_lim, quant_inc, idle_inc;
  logic [TIME_BITS-1:0] f_arr, f_start, fin_time;
  logic                 f_started;
  logic                 fin, dem, promote, keep, wlast, time_adv;
  logic [EXT_W-1:0]     arr_ext, start_ext, fin_ext;

  assign f_id      = ib_q[23:16];
  assign f_burst   = ib_q[15:0];
  assign f_exec    = pr_q[31:16];
  assign f_quant   = pr_q[15:8];
  assign f_idle    = pr_q[7:0];
  assign f_arr     = st_q[ST_W-1:TIME_BITS+1];
  assign f_start   = st_q[TIME_BITS:1];
  assign f_started = st_q[0];

  always_comb begin
    case (lvl_r)
      LVL_TOP: begin
        ord_sel = ord0_q; fill_cur = fill0_r; fill_dn = fill1_r; fill_up = fill0_r;
      end
      LVL_MID: begin
        ord_sel = ord1_q; fill_cur = fill1_r; fill_dn = fill2_r; fill_up = fill0_r;
      end
      default: begin
        ord_sel = ord2_q; fill_cur = fill2_r; fill_dn = fill2_r; fill_up = fill1_r;
      end
    endcase
  end

  assign ord_raddr = (cmd.act == ACT_WRD) ? i_r[SLOT_W-1:0] : '0;

  assign quant_lim = (lvl_r == LVL_TOP) ? {2'b00, top_q_r} : {2'b00, mid_q_r};
  assign quant_inc = (f_quant == CNT8_MAX) ? f_quant : f_quant + 8'd1;
  assign idle_inc  = (f_idle == CNT8_MAX) ? f_idle : f_idle + 8'd1;
  assign fin       = (f_exec >= f_burst);
  assign dem       = !fin && (lvl_r != LVL_BOT) && (f_quant >= quant_lim);
  assign fin_time  = (time_r == '0) ? '0 : time_r - 1'b1;
  assign arr_ext   = EXT_W'(f_arr);
  assign start_ext = EXT_W'(f_start);
  assign fin_ext   = EXT_W'(fin_time);
  assign time_nxt  = (time_r == TIME_MAX) ? time_r : time_r + 1'b1;
  assign time_adv  = (cmd.act == ACT_IDLETICK) || ((cmd.act == ACT_DECIDE) && !dem);

  // walk: served entry is dropped when removed, otherwise kept without aging
  assign wlast   = (i_r == fill_cur - 1'b1);
  assign promote = (i_r != '0) && (lvl_r != LVL_TOP) && (idle_inc > aging_r);
  assign keep    = (i_r == '0) ? !removed_r : !promote;
  assign n_nxt   = keep ? n_r + 1'b1 : n_r;

  always_comb begin
    fill_nxt[0] = fill0_r;
    fill_nxt[1] = fill1_r;
    fill_nxt[2] = fill2_r;
    for (int k = 0; k < 3; k++) begin
      ord_we[k] = 1'b0;
      ord_wa[k] = '0;
    end
    case (cmd.act)
      ACT_ALLOC: begin
        if (fill0_r < FILL_MAX) begin
          ord_we[0]   = 1'b1;
          ord_wa[0]   = fill0_r[SLOT_W-1:0];
          fill_nxt[0] = fill0_r + 1'b1;
        end
      end
      ACT_DECIDE: begin
        if (dem && (fill_dn < FILL_MAX)) begin
          ord_we[lvl_r + 2'd1]   = 1'b1;
          ord_wa[lvl_r + 2'd1]   = fill_dn[SLOT_W-1:0];
          fill_nxt[lvl_r + 2'd1] = fill_dn + 1'b1;
        end
      end
      ACT_WUPD: begin
        if (keep) begin
          ord_we[lvl_r] = 1'b1;
          ord_wa[lvl_r] = n_r[SLOT_W-1:0];
        end
        if (promote && (fill_up < FILL_MAX)) begin
          ord_we[lvl_r - 2'd1]   = 1'b1;
          ord_wa[lvl_r - 2'd1]   = fill_up[SLOT_W-1:0];
          fill_nxt[lvl_r - 2'd1] = fill_up + 1'b1;
        end
        if (wlast) fill_nxt[lvl_r] = n_nxt;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    ord0_q <= ord0_mem[ord_raddr];
    ord1_q <= ord1_mem[ord_raddr];
    ord2_q <= ord2_mem[ord_raddr];
    ib_q   <= ib_mem[ord_sel];
    pr_q   <= pr_mem[ord_sel];
    st_q   <= st_mem[ord_sel];
    if (ord_we[0]) ord0_mem[ord_wa[0]] <= (cmd.act == ACT_ALLOC) ? scan_r : slot_r;
    if (ord_we[1]) ord1_mem[ord_wa[1]] <= slot_r;
    if (ord_we[2]) ord2_mem[ord_wa[2]] <= slot_r;
    case (cmd.act)
      ACT_ALLOC: begin
        ib_mem[scan_r] <= {id_r, burst_r};
        pr_mem[scan_r] <= '0;
        st_mem[scan_r] <= {time_r, {TIME_BITS{1'b0}}, 1'b0};
      end
      ACT_DECIDE: begin
        if (dem) begin
          pr_mem[slot_r] <= {f_exec, 8'd0, f_idle};
        end else if (!fin) begin
          pr_mem[slot_r] <= {f_exec + 16'd1, quant_inc, f_idle};
          if (!f_started) st_mem[slot_r] <= {f_arr, time_r, 1'b1};
        end
      end
      ACT_WUPD: begin
        if ((i_r != '0) && (lvl_r != LVL_TOP)) begin
          pr_mem[slot_r] <= {f_exec, f_quant, promote ? 8'd0 : idle_inc};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_q_r     <= TOP_Q_RST;
      mid_q_r     <= MID_Q_RST;
      aging_r     <= AGING_RST;
      time_r      <= '0;
      in_use_r    <= '0;
      cnt_r       <= '0;
      fill0_r     <= '0;
      fill1_r     <= '0;
      fill2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOP_Q: top_q_r <= cfg_data[5:0];
          CFG_MID_Q: mid_q_r <= cfg_data[5:0];
          CFG_AGING: aging_r <= cfg_data;
          default: ;
        endcase
      end
      if (time_adv) time_r <= time_nxt;
      fill0_r <= fill_nxt[0];
      fill1_r <= fill_nxt[1];
      fill2_r <= fill_nxt[2];
      if (cmd.act == ACT_ALLOC) begin
        in_use_r[scan_r] <= 1'b1;
        cnt_r            <= cnt_r + 1'b1;
      end
      if ((cmd.act == ACT_DECIDE) && fin) begin
        in_use_r[slot_r] <= 1'b0;
        cnt_r            <= cnt_r - 1'b1;
      end
      out_valid_r <= (cmd.act == ACT_REJECT) || (cmd.act == ACT_IDLETICK) ||
                     (cmd.act == ACT_ALLOC) || (cmd.act == ACT_DECIDE);
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LATCH: begin
        op_r    <= in_op;
        id_r    <= in_job_id;
        burst_r <= in_burst;
        scan_r  <= '0;
        if (fill0_r != '0)      lvl_r <= LVL_TOP;
        else if (fill1_r != '0) lvl_r <= LVL_MID;
        else                    lvl_r <= LVL_BOT;
      end
      ACT_SCAN: begin
        if (in_use_r[scan_r]) scan_r <= scan_r + 1'b1;
      end
      ACT_SLOT, ACT_WSLOT: slot_r <= ord_sel;
      ACT_DECIDE: begin
        removed_r <= fin || dem;
        i_r       <= '0;
        n_r       <= '0;
      end
      ACT_WUPD: begin
        i_r <= i_r + 1'b1;
        n_r <= n_nxt;
      end
      default: ;
    endcase

    out_status_r <= ST_IDLE;
    out_id_r     <= 8'd0;
    out_lvl_r    <= LVL_TOP;
    out_arr_r    <= 16'd0;
    out_start_r  <= 16'd0;
    out_fin_r    <= 16'd0;
    case (cmd.act)
      ACT_REJECT: out_status_r <= ST_REJECTED;
      ACT_ALLOC: begin
        out_status_r <= ST_ACCEPTED;
        out_id_r     <= id_r;
      end
      ACT_DECIDE: begin
        if (fin) begin
          out_status_r <= ST_FINISHED;
          out_id_r     <= f_id;
          out_lvl_r    <= lvl_r;
          out_arr_r    <= arr_ext[15:0];
          out_start_r  <= start_ext[15:0];
          out_fin_r    <= fin_ext[15:0];
        end else if (!dem) begin
          out_status_r <= ST_RAN;
          out_id_r     <= f_id;
          out_lvl_r    <= lvl_r;
        end
      end
      default: ;
    endcase
  end

  assign stat.op          = op_r;
  assign stat.burst_zero  = (burst_r == 16'd0);
  assign stat.full        = (cnt_r == FILL_MAX);
  assign stat.slot_free   = !in_use_r[scan_r];
  assign stat.lvl_none    = (fill0_r == '0) && (fill1_r == '0) && (fill2_r == '0);
  assign stat.walk_needed = fin || dem || (lvl_r != LVL_TOP);
  assign stat.walk_last   = wlast;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_served_id     = out_id_r;
  assign out_served_level  = out_lvl_r;
  assign out_arrival_stamp = out_arr_r;
  assign out_start_stamp   = out_start_r;
  assign out_finish_stamp  = out_fin_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FILL_MAX)
    else $error("job count above store depth");
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_WUPD) |-> (i_r < fill_cur))
    else $error("aging walk ran past queue fill");
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_ALLOC) |-> !in_use_r[scan_r])
    else $error("allocation into a slot in use");

endmodule

@@ rtl/three_level_feedback_queue_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Arrival: latched and checked, then rejected, or a free slot is scanned for and allocated.
// Tick: idle result if all queues are empty; else head and slot read, result decided, then,
// unless a top-level job stays, a read/slot/update walk over the level before busy drops.
// Serialized by the 1R1W job store and queue memories; one item at a time.
// Synchronous active-low reset: queues empty, time zero, quanta 8/16, threshold 15.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
module three_level_feedback_queue_scheduler_unit #(
  parameter int MAX_JOBS  = tlfq_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = tlfq_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [7:0]  in_job_id,
  input  logic [15:0] in_burst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_served_id,
  output logic [1:0]  out_served_level,
  output logic [15:0] out_arrival_stamp,
  output logic [15:0] out_start_stamp,
  output logic [15:0] out_finish_stamp
);
  import tlfq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tlfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tlfq_dp #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_job_id         (in_job_id),
    .in_burst          (in_burst),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_served_id     (out_served_id),
    .out_served_level  (out_served_level),
    .out_arrival_stamp (out_arrival_stamp),
    .out_start_stamp   (out_start_stamp),
    .out_finish_stamp  (out_finish_stamp)
  );

endmodule
